// ===== hdl/ppr_pkg.sv =====
// ----------------------------------------------------------------------------
// ppr_pkg
// Shared constants and controller/datapath interface types for the page
// replacement policy block.
// ----------------------------------------------------------------------------
package ppr_pkg;

    localparam int MAX_FRAMES = 64;
    localparam int FRAME_W    = $clog2(MAX_FRAMES);
    localparam int COUNT_W    = FRAME_W + 1;
    localparam int PAGE_W     = 10;
    localparam int AGE_W      = 8;
    localparam int MODE_W     = 2;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 24;
    localparam int CFG_DATA_W = 7;

    localparam logic [AGE_W-1:0]   AGE_TOP   = AGE_W'(1) << (AGE_W - 1);
    localparam logic [FRAME_W-1:0] RANK_MAX  = FRAME_W'(MAX_FRAMES - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_FRAMES);

    localparam logic [MODE_W-1:0] MODE_FIFO = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ARB  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ESC  = 2'd2;

    localparam logic CFG_POLICY_MODE   = 1'b0;
    localparam logic CFG_FRAMES_IN_USE = 1'b1;

    typedef struct packed {
        logic load;
        logic scan;
        logic decide;
        logic commit;
    } ppr_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_busy;
    } ppr_status_t;

endpackage

// ===== hdl/ppr_ctrl.sv =====
// ----------------------------------------------------------------------------
// ppr_ctrl
// Sequencer for one page reference: accept, scan the frame table, choose the
// frame, then commit the update and hand the result word to the output.
// ----------------------------------------------------------------------------
module ppr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  ppr_pkg::ppr_status_t status,
    output ppr_pkg::ppr_cmd_t    cmd
);
    import ppr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_DECIDE,
        ST_COMMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_SCAN;
            ST_SCAN:   if (status.scan_last) state_next = ST_FLUSH;
            ST_FLUSH:  state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_COMMIT;
            ST_COMMIT: if (!status.out_busy) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign cmd.load   = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.scan   = (state_reg == ST_SCAN);
    assign cmd.decide = (state_reg == ST_DECIDE);
    assign cmd.commit = (state_reg == ST_COMMIT) && !status.out_busy;

endmodule

// ===== hdl/ppr_datapath.sv =====
// ----------------------------------------------------------------------------
// ppr_datapath
// Frame table memory, per-frame policy cells, scan trackers, victim choice,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module ppr_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ppr_pkg::ppr_cmd_t                 cmd,
    output ppr_pkg::ppr_status_t              status,
    input  logic [ppr_pkg::S_DATA_W-1:0]      s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ppr_pkg::M_DATA_W-1:0]      m_tdata,
    input  logic                              cfg_valid,
    input  logic                              cfg_index,
    input  logic [ppr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ppr_pkg::*;

    localparam int NTRK = 6;

    // configuration
    logic [MODE_W-1:0]  mode_reg;
    logic [COUNT_W-1:0] frames_reg;
    logic [COUNT_W-1:0] n_act;
    logic [FRAME_W-1:0] start_idx;

    // captured reference
    logic [PAGE_W-1:0] page_reg;
    logic              wr_reg;

    // frame table and per-frame cells
    logic [PAGE_W-1:0]  page_mem [MAX_FRAMES];
    logic [PAGE_W-1:0]  rd_data_reg;
    logic [FRAME_W-1:0] rd_addr;
    logic               valid_reg [MAX_FRAMES];
    logic               dirty_reg [MAX_FRAMES];
    logic               sc_reg    [MAX_FRAMES];
    logic [AGE_W-1:0]   age_reg   [MAX_FRAMES];
    logic [FRAME_W-1:0] rank_reg  [MAX_FRAMES];
    logic [FRAME_W-1:0] hand_reg;

    // scan
    logic [FRAME_W-1:0] cnt_reg;
    logic               cmp_v_reg;
    logic [FRAME_W-1:0] jdx_reg;
    logic               hit_f_reg, emp_f_reg;
    logic [FRAME_W-1:0] hit_i_reg, emp_i_reg, arb_i_reg;
    logic               esc_f_reg [NTRK];
    logic [FRAME_W-1:0] esc_i_reg [NTRK];
    logic               esc_cond  [NTRK];

    // decision
    logic [FRAME_W-1:0] pick;
    logic               pick_hit, pick_evict, pick_clr, esc_found;
    logic [FRAME_W-1:0] esc_pick;
    logic [FRAME_W-1:0] f_reg;
    logic               hit_reg, evict_reg, clr_reg;
    logic [FRAME_W-1:0] f_rank;
    logic [FRAME_W-1:0] hand_inc;

    // output word
    logic               m_tvalid_reg;
    logic               o_hit_reg, o_ev_reg, o_wb_reg;
    logic [FRAME_W-1:0] o_frame_reg;
    logic [PAGE_W-1:0]  o_page_reg;

    always_comb begin
        if (frames_reg == '0) begin
            n_act = COUNT_W'(1);
        end else if (frames_reg > COUNT_MAX) begin
            n_act = COUNT_MAX;
        end else begin
            n_act = frames_reg;
        end
    end

    assign start_idx = ({1'b0, hand_reg} < n_act) ? hand_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_FIFO;
            frames_reg <= COUNT_MAX;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_POLICY_MODE:   mode_reg   <= cfg_data[MODE_W-1:0];
                CFG_FRAMES_IN_USE: frames_reg <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            page_reg <= s_tdata[PAGE_W-1:0];
            wr_reg   <= s_tdata[PAGE_W];
        end
    end

    // frame table memory, registered read; the victim's page is held through commit
    assign rd_addr = cmd.decide ? pick : cnt_reg;

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            page_mem[f_reg] <= page_reg;
        end
        if (cmd.scan || cmd.decide) begin
            rd_data_reg <= page_mem[rd_addr];
        end
    end

    // scan counter and compare stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            cmp_v_reg <= 1'b0;
        end else begin
            cmp_v_reg <= cmd.scan;
            if (cmd.load) begin
                cnt_reg <= '0;
            end else if (cmd.scan) begin
                cnt_reg <= cnt_reg + FRAME_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        jdx_reg <= cnt_reg;
    end

    assign status.scan_last = ({1'b0, cnt_reg} == n_act - COUNT_W'(1));
    assign status.out_busy  = m_tvalid_reg && !m_tready;

    // clock classes: (0,0) from the hand, (0,0) before it, (0,1) likewise,
    // then clean pages for the pass after clearing reference bits
    always_comb begin
        esc_cond[0] = !sc_reg[jdx_reg] && !dirty_reg[jdx_reg] && (jdx_reg >= start_idx);
        esc_cond[1] = !sc_reg[jdx_reg] && !dirty_reg[jdx_reg] && (jdx_reg <  start_idx);
        esc_cond[2] = !sc_reg[jdx_reg] &&  dirty_reg[jdx_reg] && (jdx_reg >= start_idx);
        esc_cond[3] = !sc_reg[jdx_reg] &&  dirty_reg[jdx_reg] && (jdx_reg <  start_idx);
        esc_cond[4] = !dirty_reg[jdx_reg] && (jdx_reg >= start_idx);
        esc_cond[5] = !dirty_reg[jdx_reg] && (jdx_reg <  start_idx);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            hit_f_reg <= 1'b0;
            emp_f_reg <= 1'b0;
            arb_i_reg <= '0;
            for (int k = 0; k < NTRK; k++) begin
                esc_f_reg[k] <= 1'b0;
            end
        end else if (cmp_v_reg) begin
            if (!hit_f_reg && valid_reg[jdx_reg] && (rd_data_reg == page_reg)) begin
                hit_f_reg <= 1'b1;
                hit_i_reg <= jdx_reg;
            end
            if (!emp_f_reg && !valid_reg[jdx_reg]) begin
                emp_f_reg <= 1'b1;
                emp_i_reg <= jdx_reg;
            end
            if ((age_reg[jdx_reg] < age_reg[arb_i_reg]) ||
                ((age_reg[jdx_reg] == age_reg[arb_i_reg]) &&
                 (rank_reg[jdx_reg] < rank_reg[arb_i_reg]))) begin
                arb_i_reg <= jdx_reg;
            end
            for (int k = 0; k < NTRK; k++) begin
                if (!esc_f_reg[k] && esc_cond[k]) begin
                    esc_f_reg[k] <= 1'b1;
                    esc_i_reg[k] <= jdx_reg;
                end
            end
        end
    end

    always_comb begin
        esc_found = 1'b0;
        esc_pick  = start_idx;
        for (int k = NTRK - 1; k >= 0; k--) begin
            if (esc_f_reg[k]) begin
                esc_found = 1'b1;
                esc_pick  = esc_i_reg[k];
            end
        end
    end

    always_comb begin
        pick_hit   = 1'b0;
        pick_evict = 1'b0;
        pick_clr   = 1'b0;
        if (hit_f_reg) begin
            pick     = hit_i_reg;
            pick_hit = 1'b1;
        end else if (emp_f_reg) begin
            pick = emp_i_reg;
        end else begin
            pick_evict = 1'b1;
            case (mode_reg)
                MODE_ARB: pick = arb_i_reg;
                MODE_ESC: begin
                    pick     = esc_found ? esc_pick : start_idx;
                    pick_clr = !(esc_f_reg[0] || esc_f_reg[1] ||
                                 esc_f_reg[2] || esc_f_reg[3]);
                end
                default:  pick = start_idx;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            f_reg     <= pick;
            hit_reg   <= pick_hit;
            evict_reg <= pick_evict;
            clr_reg   <= pick_clr;
        end
    end

    assign f_rank   = rank_reg[f_reg];
    assign hand_inc = ({1'b0, f_reg} + COUNT_W'(1) == n_act) ? '0 : f_reg + FRAME_W'(1);

    // per-frame cells, all updated together on commit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hand_reg <= '0;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                valid_reg[i] <= 1'b0;
                dirty_reg[i] <= 1'b0;
                sc_reg[i]    <= 1'b0;
                age_reg[i]   <= '0;
                rank_reg[i]  <= FRAME_W'(i);
            end
        end else if (cmd.commit) begin
            for (int i = 0; i < MAX_FRAMES; i++) begin
                age_reg[i] <= age_reg[i] >> 1;
                if (rank_reg[i] > f_rank) begin
                    rank_reg[i] <= rank_reg[i] - FRAME_W'(1);
                end
                if (clr_reg && (COUNT_W'(i) < n_act)) begin
                    sc_reg[i] <= 1'b0;
                end
            end
            valid_reg[f_reg] <= 1'b1;
            sc_reg[f_reg]    <= 1'b1;
            rank_reg[f_reg]  <= RANK_MAX;
            if (hit_reg) begin
                dirty_reg[f_reg] <= dirty_reg[f_reg] | wr_reg;
                age_reg[f_reg]   <= (age_reg[f_reg] >> 1) | AGE_TOP;
            end else begin
                dirty_reg[f_reg] <= wr_reg;
                age_reg[f_reg]   <= AGE_TOP;
            end
            if (evict_reg && (mode_reg != MODE_ARB)) begin
                hand_reg <= hand_inc;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            o_hit_reg   <= hit_reg;
            o_frame_reg <= f_reg;
            o_ev_reg    <= evict_reg;
            o_wb_reg    <= evict_reg && dirty_reg[f_reg];
            o_page_reg  <= evict_reg ? rd_data_reg : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'({o_page_reg, o_wb_reg, o_ev_reg, o_frame_reg, o_hit_reg});

`ifndef SYNTHESIS
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !(m_tvalid_reg && !m_tready))
        else $error("commit while output word still held");

    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid_reg)
        else $error("committed result not presented");

    a_rank_top: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> (rank_reg[$past(f_reg)] == RANK_MAX))
        else $error("touched frame not most recent");

    a_frame_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> ({1'b0, f_reg} < n_act))
        else $error("chosen frame outside frames in use");
`endif

endmodule

// ===== hdl/page_replacement_policy.sv =====
// Sequence: an accepted word passes the scan, flush, decide and commit states, and the
// result word is registered on commit. The single pass over the frame table memory
// (one read per cycle) sets the pace; a new reference is accepted only after commit, and
// commit waits while a result word is still held by m_tready.
// Reset: synchronous active-low aresetn clears frame valid, aging, dirty and
// reference bits, restores recency order and hand; configuration to defaults.
// ----------------------------------------------------------------------------
// page_replacement_policy
// Page reference lookup with FIFO, aging and enhanced second chance victim
// selection over a table of resident pages.
// ----------------------------------------------------------------------------
module page_replacement_policy (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ppr_pkg::S_DATA_W-1:0]      s_tdata,   // page_number, is_write
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ppr_pkg::M_DATA_W-1:0]      m_tdata,   // hit, frame_index, evicted_valid,
                                                         // write_back, evicted_page
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [ppr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ppr_pkg::*;

    ppr_cmd_t    cmd;
    ppr_status_t status;

    assign cfg_ready = 1'b1;

    ppr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ppr_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// ===== test/page_replacement_policy_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_replacement_policy_tb
// Drives page references through every replacement mode and a range of frame counts,
// predicts hit, frame and eviction per reference and checks each result word.
// ----------------------------------------------------------------------------
module page_replacement_policy_tb;
    import ppr_pkg::*;

    typedef struct packed {
        logic [PAGE_W-1:0]  evicted_page;
        logic               write_back;
        logic               evicted_valid;
        logic [FRAME_W-1:0] frame_index;
        logic               hit;
    } ppr_result_t;

    class frame_table_scoreboard;
        logic [PAGE_W-1:0]  page_of [MAX_FRAMES];
        logic               resident [MAX_FRAMES];
        logic [AGE_W-1:0]   age [MAX_FRAMES];
        logic [FRAME_W-1:0] rank [MAX_FRAMES];
        logic               ref_bit [MAX_FRAMES];
        logic               dirty [MAX_FRAMES];
        logic [FRAME_W-1:0] hand;
        logic [MODE_W-1:0]  mode;
        logic [COUNT_W-1:0] frame_count;
        ppr_result_t        pending [$];
        int                 errors;

        function void clear();
            for (int i = 0; i < MAX_FRAMES; i++) begin
                page_of[i] = '0; resident[i] = 0; age[i] = '0;
                rank[i] = FRAME_W'(i); ref_bit[i] = 0; dirty[i] = 0;
            end
            hand = '0; mode = MODE_FIFO; frame_count = COUNT_MAX; errors = 0;
        endfunction

        function void mark_used(int f, bit fresh);
            logic [FRAME_W-1:0] r;
            r = rank[f];
            for (int i = 0; i < MAX_FRAMES; i++) begin
                age[i] = age[i] >> 1;
                if (rank[i] > r) rank[i]--;
            end
            rank[f] = RANK_MAX;
            age[f] = fresh ? AGE_TOP : (age[f] | AGE_TOP);
            ref_bit[f] = 1;
        endfunction

        function int clock_search(int n, int start);
            int p;
            for (int rnd = 0; rnd < 2; rnd++) begin
                for (int cls = 0; cls < 2; cls++)
                    for (int k = 0; k < n; k++) begin
                        p = (start + k) % n;
                        if (!ref_bit[p] && dirty[p] == cls) return p;
                    end
                for (int k = 0; k < n; k++) ref_bit[k] = 0;
            end
            return start;
        endfunction

        function void note_reference(logic [PAGE_W-1:0] pg, logic wr);
            int n, f, st;
            bit found;
            ppr_result_t res;
            n = frame_count; f = 0; found = 0; res = '0;
            if (n == 0) n = 1;
            if (n > MAX_FRAMES) n = MAX_FRAMES;
            for (int i = 0; i < n && !found; i++)
                if (resident[i] && page_of[i] == pg) begin f = i; found = 1; end
            if (found) begin
                res.hit = 1;
                dirty[f] = dirty[f] | wr;
                mark_used(f, 0);
            end else begin
                for (int i = 0; i < n && !found; i++)
                    if (!resident[i]) begin f = i; found = 1; end
                if (!found) begin
                    st = (hand < n) ? hand : 0;
                    if (mode == MODE_ARB) begin
                        f = 0;
                        for (int i = 1; i < n; i++)
                            if (age[i] < age[f] || (age[i] == age[f] && rank[i] < rank[f]))
                                f = i;
                    end else begin
                        f = (mode == MODE_ESC) ? clock_search(n, st) : st;
                        hand = FRAME_W'((f + 1) % n);
                    end
                    res.evicted_valid = 1;
                    res.write_back = dirty[f];
                    res.evicted_page = page_of[f];
                end
                page_of[f] = pg; resident[f] = 1; dirty[f] = wr;
                mark_used(f, 1);
            end
            res.frame_index = FRAME_W'(f);
            pending.push_back(res);
        endfunction

        task report_error(string msg);
            errors++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_result(logic [M_DATA_W-1:0] word);
            ppr_result_t got, exp_r;
            got = word[$bits(ppr_result_t)-1:0];
            if (pending.size() == 0) begin
                report_error("result word with nothing expected"); return;
            end
            exp_r = pending.pop_front();
            if (got.hit != exp_r.hit)
                report_error($sformatf("hit %0d exp %0d", got.hit, exp_r.hit));
            if (got.frame_index != exp_r.frame_index)
                report_error($sformatf("frame %0d exp %0d", got.frame_index, exp_r.frame_index));
            if (got.evicted_valid != exp_r.evicted_valid)
                report_error($sformatf("evicted_valid %0d exp %0d",
                    got.evicted_valid, exp_r.evicted_valid));
            if (got.write_back != exp_r.write_back)
                report_error($sformatf("write_back %0d exp %0d",
                    got.write_back, exp_r.write_back));
            if (got.evicted_page != exp_r.evicted_page)
                report_error($sformatf("evicted_page %0d exp %0d",
                    got.evicted_page, exp_r.evicted_page));
            if (word[M_DATA_W-1:$bits(ppr_result_t)] != '0) report_error("padding bits not zero");
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    frame_table_scoreboard sb;
    bit                    stall_free;

    page_replacement_policy uut (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    endfunction

    // result side: random back-pressure except in stall-free phases, checked on every accepted word
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        if (!aresetn) m_tready <= 0;
        else if (stall_free) m_tready <= 1;
        else m_tready <= ($urandom_range(0, 9) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
    end

    // valid stays high into the next word when there is no gap
    task automatic send_ref(logic [PAGE_W-1:0] pg, logic wr);
        int gap;
        gap = stall_free ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= S_DATA_W'({wr, pg});
        do @(posedge aclk); while (!s_tready);
        sb.note_reference(pg, wr);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (MAX_FRAMES + 10) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_POLICY_MODE) sb.mode = val[MODE_W-1:0];
        else sb.frame_count = val;
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    // references mostly from a small working set so hits and evictions both occur
    task automatic random_refs(int count, int span);
        int base;
        base = $urandom_range(0, 1023 - span);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 7) == 0) send_ref(PAGE_W'($urandom), 1'($urandom));
            else send_ref(PAGE_W'(base + $urandom_range(0, span)), 1'($urandom));
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        aresetn = 0; s_tvalid = 0; s_tdata = '0;
        cfg_valid = 0; cfg_index = CFG_POLICY_MODE; cfg_data = '0;
        stall_free = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: default 64 frames, fill then hits at page extremes
        send_ref(10'd0, 1'b0);
        send_ref(10'd1023, 1'b1);
        send_ref(10'd0, 1'b1);
        send_ref(10'd1023, 1'b0);
        send_ref(10'h2AA, 1'b1);
        send_ref(10'h155, 1'b0);
        drain();
        write_reg(CFG_FRAMES_IN_USE, 7'd1);
        send_ref(10'd5, 1'b1);
        send_ref(10'd6, 1'b0);
        send_ref(10'd6, 1'b1);
        drain();
        // zero count acts as one, above range acts as full table
        write_reg(CFG_FRAMES_IN_USE, 7'd0);
        send_ref(10'd7, 1'b0);
        drain();
        write_reg(CFG_FRAMES_IN_USE, 7'd127);
        send_ref(10'd7, 1'b1);
        drain();
        write_reg(CFG_FRAMES_IN_USE, 7'd3);
        write_reg(CFG_POLICY_MODE, CFG_DATA_W'(MODE_ARB));
        for (int i = 0; i < 5; i++) send_ref(PAGE_W'(20 + i), 1'(i));
        drain();
        write_reg(CFG_POLICY_MODE, CFG_DATA_W'(MODE_ESC));
        for (int i = 0; i < 5; i++) send_ref(PAGE_W'(22 + i), 1'(i + 1));
        drain();
        // unused mode behaves as fifo
        write_reg(CFG_POLICY_MODE, 7'd3);
        send_ref(10'd30, 1'b0);
        send_ref(10'd31, 1'b1);

        // random phases across modes and frame counts
        for (int ph = 0; ph < 28; ph++) begin
            drain();
            stall_free = (ph % 7 == 3);
            write_reg(CFG_POLICY_MODE, CFG_DATA_W'(ph % 4));
            case (ph % 5)
                0: write_reg(CFG_FRAMES_IN_USE, 7'd64);
                1: write_reg(CFG_FRAMES_IN_USE, 7'd1);
                2: write_reg(CFG_FRAMES_IN_USE, 7'd2);
                default: write_reg(CFG_FRAMES_IN_USE, 7'($urandom_range(3, 16)));
            endcase
            random_refs(25, (ph % 5 == 0) ? 90 : 3 * sb.frame_count + 2);
            drain();
            random_refs(25, (ph % 5 == 0) ? 90 : 3 * sb.frame_count + 2);
        end
        stall_free = 0;
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ===== page_replacement_policy.f =====
hdl/ppr_pkg.sv
hdl/ppr_ctrl.sv
hdl/ppr_datapath.sv
hdl/page_replacement_policy.sv
test/page_replacement_policy_tb.sv
